/* hw/rtl/assert_macros.svh */
// assertion helpers used by the rtl (qsvn_merge), compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every rising clk edge outside reset
`define QSVN_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising clk edge, reset included
`define QSVN_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSVN_ASSERT(name, prop, msg)
`define QSVN_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

/* hw/rtl/qsvn_pkg.sv */
// ----------------------------------------------------------------------------
// qsvn_pkg
// widths, types and constants of the quad surface vertex normals unit
// ----------------------------------------------------------------------------
package qsvn_pkg;

    localparam int COORD_W          = 32;
    localparam int EDGE_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * EDGE_W;
    localparam int CROSS_W          = PROD_W + 1;
    localparam int MAG_W            = PROD_W;
    localparam int HALF_W           = (MAG_W + 1) / 2;
    localparam int PP_W             = 2 * HALF_W;
    localparam int SQ_W             = 2 * MAG_W;
    localparam int LEN_W            = SQ_W + 2;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int RES_W            = NORMAL_FRAC_BITS + 1;
    localparam int NORM_BITS        = RES_W;
    localparam int NORM_W           = 16;
    localparam int T_W              = SQ_W + 2 * NORMAL_FRAC_BITS + 2;
    localparam int U_W              = LEN_W + 2 * RES_W;
    localparam int V_W              = LEN_W + RES_W + 1;
    localparam int N_W              = U_W + 2;
    localparam int SHIFT_W          = 4;
    localparam int SHL_W            = LEN_W + 2 * ((1 << SHIFT_W) - 1);

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(6);
    localparam logic signed [NORM_W-1:0] UNIT_POS = NORM_W'(1 << NORMAL_FRAC_BITS);
    localparam logic signed [NORM_W-1:0] UNIT_NEG = -UNIT_POS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [LEN_W-1:0]          len_t;

    typedef struct packed {
        logic       vld;
        logic [1:0] idx;
    } job_t;

    typedef struct packed {
        logic                   vld;
        logic [1:0]             idx;
        logic [2:0][NORM_W-1:0] n;
        len_t                   len2;
    } vec_res_t;

endpackage

/* hw/rtl/qsvn_cross.sv */
// ----------------------------------------------------------------------------
// qsvn_cross
// cross product of an edge vector pair, squared components and squared length
// ----------------------------------------------------------------------------
module qsvn_cross (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  qsvn_pkg::job_t    job_in,
    input  qsvn_pkg::edge_t   a [3],
    input  qsvn_pkg::edge_t   b [3],
    output qsvn_pkg::job_t    job_out,
    output logic [2:0]        neg,
    output qsvn_pkg::sq_t     sq [3],
    output qsvn_pkg::len_t    len2
);
    import qsvn_pkg::*;

    job_t                      job_reg [6];
    logic signed [PROD_W-1:0]  p_reg [3];
    logic signed [PROD_W-1:0]  q_reg [3];
    logic signed [CROSS_W-1:0] c_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [2:0]                neg3_reg;
    logic [2:0]                neg4_reg;
    logic [2:0]                neg5_reg;
    logic [2:0]                neg6_reg;
    logic [PP_W-1:0]           hh_reg [3];
    logic [PP_W-1:0]           hl_reg [3];
    logic [PP_W-1:0]           ll_reg [3];
    sq_t                       sq5_reg [3];
    sq_t                       sq6_reg [3];
    len_t                      len2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 6; s++)
            begin
                job_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            job_reg[0] <= job_in;
            for (int s = 1; s < 6; s++)
            begin
                job_reg[s] <= job_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_comp
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_reg[k]    <= PROD_W'(a[K1]) * PROD_W'(b[K2]);
                q_reg[k]    <= PROD_W'(a[K2]) * PROD_W'(b[K1]);
                c_reg[k]    <= CROSS_W'(p_reg[k]) - CROSS_W'(q_reg[k]);
                neg3_reg[k] <= c_reg[k][CROSS_W-1];
                mag_reg[k]  <= c_reg[k][CROSS_W-1] ? MAG_W'(-c_reg[k]) : MAG_W'(c_reg[k]);
                // square split into three partial products
                hh_reg[k]   <= PP_W'(mag_reg[k][MAG_W-1:HALF_W]) *
                               PP_W'(mag_reg[k][MAG_W-1:HALF_W]);
                hl_reg[k]   <= PP_W'(mag_reg[k][MAG_W-1:HALF_W]) *
                               PP_W'(mag_reg[k][HALF_W-1:0]);
                ll_reg[k]   <= PP_W'(mag_reg[k][HALF_W-1:0]) *
                               PP_W'(mag_reg[k][HALF_W-1:0]);
                sq5_reg[k]  <= (SQ_W'(hh_reg[k]) << (2 * HALF_W)) +
                               (SQ_W'(hl_reg[k]) << (HALF_W + 1)) + SQ_W'(ll_reg[k]);
                sq6_reg[k]  <= sq5_reg[k];
            end
        end

        assign sq[k] = sq6_reg[k];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            neg6_reg <= neg5_reg;
            len2_reg <= LEN_W'(sq5_reg[0]) + LEN_W'(sq5_reg[1]) + LEN_W'(sq5_reg[2]);
        end
    end

    assign job_out = job_reg[5];
    assign neg     = neg6_reg;
    assign len2    = len2_reg;

endmodule

/* hw/rtl/qsvn_norm.sv */
// ----------------------------------------------------------------------------
// qsvn_norm
// one component of a unit normal, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module qsvn_norm (
    input  logic                         clk,
    input  logic                         adv,
    input  qsvn_pkg::len_t               s,
    input  qsvn_pkg::sq_t                sq,
    output logic [qsvn_pkg::RES_W-1:0]   r
);
    import qsvn_pkg::*;

    // u = 2r-1 tracked as u*u*s and u*s, starting from r = 0
    logic [U_W-1:0]        u_reg [NORM_BITS+1];
    logic signed [V_W-1:0] v_reg [NORM_BITS+1];
    logic [T_W-1:0]        t_reg [NORM_BITS+1];
    len_t                  s_reg [NORM_BITS+1];
    logic [RES_W-1:0]      r_reg [NORM_BITS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg[0] <= U_W'(s);
            v_reg[0] <= V_W'(0) - V_W'(s);
            t_reg[0] <= T_W'(sq) << (2 * NORMAL_FRAC_BITS + 2);
            s_reg[0] <= s;
            r_reg[0] <= '0;
        end
    end

    for (genvar i = 1; i <= NORM_BITS; i++)
    begin : g_step
        localparam int J = NORM_BITS - i;

        logic [N_W-1:0] u_cand;
        logic           take;

        always_comb
        begin
            u_cand = N_W'(u_reg[i-1]) + (N_W'(v_reg[i-1]) << (J + 2)) +
                     (N_W'(s_reg[i-1]) << (2 * J + 2));
            // result never exceeds one, so no lower bit once the top one is set
            take   = !r_reg[i-1][RES_W-1] && (u_cand <= N_W'(t_reg[i-1]));
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                t_reg[i] <= t_reg[i-1];
                s_reg[i] <= s_reg[i-1];
                if (take)
                begin
                    u_reg[i] <= U_W'(u_cand);
                    v_reg[i] <= v_reg[i-1] + (V_W'(s_reg[i-1]) << (J + 1));
                    r_reg[i] <= r_reg[i-1] | (RES_W'(1) << J);
                end
                else
                begin
                    u_reg[i] <= u_reg[i-1];
                    v_reg[i] <= v_reg[i-1];
                    r_reg[i] <= r_reg[i-1];
                end
            end
        end
    end

    assign r = r_reg[NORM_BITS];

endmodule

/* hw/rtl/qsvn_vec_pipe.sv */
// ----------------------------------------------------------------------------
// qsvn_vec_pipe
// edge pair to signed unit normal: cross product and three component lanes
// ----------------------------------------------------------------------------
module qsvn_vec_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  qsvn_pkg::job_t     job_in,
    input  qsvn_pkg::edge_t    a [3],
    input  qsvn_pkg::edge_t    b [3],
    output qsvn_pkg::vec_res_t res
);
    import qsvn_pkg::*;

    job_t             cr_job;
    logic [2:0]       cr_neg;
    sq_t              cr_sq [3];
    len_t             cr_len2;
    logic [RES_W-1:0] lane_r [3];

    job_t             job_line_reg [NORM_BITS+1];
    logic [2:0]       neg_line_reg [NORM_BITS+1];
    len_t             len_line_reg [NORM_BITS+1];

    qsvn_cross u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .job_in  (job_in),
        .a       (a),
        .b       (b),
        .job_out (cr_job),
        .neg     (cr_neg),
        .sq      (cr_sq),
        .len2    (cr_len2)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        qsvn_norm u_norm (
            .clk (clk),
            .adv (adv),
            .s   (cr_len2),
            .sq  (cr_sq[k]),
            .r   (lane_r[k])
        );
    end

    // side line that keeps job, signs and length next to the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NORM_BITS; s++)
            begin
                job_line_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            job_line_reg[0] <= cr_job;
            for (int s = 1; s <= NORM_BITS; s++)
            begin
                job_line_reg[s] <= job_line_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_line_reg[0] <= cr_neg;
            len_line_reg[0] <= cr_len2;
            for (int s = 1; s <= NORM_BITS; s++)
            begin
                neg_line_reg[s] <= neg_line_reg[s-1];
                len_line_reg[s] <= len_line_reg[s-1];
            end
        end
    end

    always_comb
    begin
        res.vld  = job_line_reg[NORM_BITS].vld;
        res.idx  = job_line_reg[NORM_BITS].idx;
        res.len2 = len_line_reg[NORM_BITS];
        for (int k = 0; k < 3; k++)
        begin
            if (len_line_reg[NORM_BITS] == '0)
            begin
                res.n[k] = '0;
            end
            else if (neg_line_reg[NORM_BITS][k])
            begin
                res.n[k] = NORM_W'(0) - NORM_W'(lane_r[k]);
            end
            else
            begin
                res.n[k] = NORM_W'(lane_r[k]);
            end
        end
    end

endmodule

/* hw/rtl/qsvn_merge.sv */
// ----------------------------------------------------------------------------
// qsvn_merge
// joins corner and quad normals, degenerate corner fallback, output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qsvn_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic [qsvn_pkg::SHIFT_W-1:0]        shift,
    input  qsvn_pkg::vec_res_t                  corner,
    input  qsvn_pkg::vec_res_t                  quad,
    output logic                                out_valid,
    output logic [1:0]                          corner_index,
    output logic signed [qsvn_pkg::NORM_W-1:0]  corner_nx,
    output logic signed [qsvn_pkg::NORM_W-1:0]  corner_ny,
    output logic signed [qsvn_pkg::NORM_W-1:0]  corner_nz,
    output logic signed [qsvn_pkg::NORM_W-1:0]  quad_nx,
    output logic signed [qsvn_pkg::NORM_W-1:0]  quad_ny,
    output logic signed [qsvn_pkg::NORM_W-1:0]  quad_nz,
    output logic                                surface_valid,
    output logic                                last_corner
);
    import qsvn_pkg::*;

    logic [2:0][NORM_W-1:0] held_n_reg;
    len_t                   held_len2_reg;
    logic [2:0][NORM_W-1:0] q_n;
    len_t                   q_len2;
    logic [2:0][NORM_W-1:0] c_n;
    logic [SHL_W-1:0]       c_scaled;
    logic                   fallback;

    logic                   out_valid_reg;
    logic [1:0]             idx_reg;
    logic [2:0][NORM_W-1:0] cn_reg;
    logic [2:0][NORM_W-1:0] qn_reg;
    logic                   sv_reg;
    logic                   last_reg;

    // quad result leaves the pipe together with corner 0 and is held for the rest
    always_ff @(posedge clk)
    begin
        if (adv && quad.vld)
        begin
            held_n_reg    <= quad.n;
            held_len2_reg <= quad.len2;
        end
    end

    always_comb
    begin
        q_n      = quad.vld ? quad.n : held_n_reg;
        q_len2   = quad.vld ? quad.len2 : held_len2_reg;
        c_scaled = SHL_W'(corner.len2) << {shift, 1'b0};
        fallback = (corner.len2 == '0) || (c_scaled <= SHL_W'(q_len2));
        c_n      = fallback ? q_n : corner.n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= corner.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && corner.vld)
        begin
            idx_reg  <= corner.idx;
            cn_reg   <= c_n;
            qn_reg   <= q_n;
            sv_reg   <= (q_len2 != '0);
            last_reg <= (corner.idx == 2'd3);
        end
    end

    assign out_valid     = out_valid_reg;
    assign corner_index  = idx_reg;
    assign corner_nx     = cn_reg[0];
    assign corner_ny     = cn_reg[1];
    assign corner_nz     = cn_reg[2];
    assign quad_nx       = qn_reg[0];
    assign quad_ny       = qn_reg[1];
    assign quad_nz       = qn_reg[2];
    assign surface_valid = sv_reg;
    assign last_corner   = last_reg;

    `QSVN_ASSERT(a_quad_with_corner0, quad.vld |-> corner.vld && (corner.idx == 2'd0), "quad result not aligned with corner 0")
    `QSVN_ASSERT(a_corner_order, adv && corner.vld && (corner.idx != 2'd3) |=> corner.vld && (corner.idx == 2'($past(corner.idx) + 2'd1)), "corner results out of order")
    `QSVN_ASSERT(a_corner_unit, out_valid |-> (corner_nx <= UNIT_POS) && (corner_nx >= UNIT_NEG) && (corner_nz <= UNIT_POS) && (corner_nz >= UNIT_NEG), "corner normal out of range")
    `QSVN_ASSERT(a_quad_zero, out_valid && !surface_valid |-> (quad_nx == '0) && (quad_ny == '0) && (quad_nz == '0), "degenerate quad with nonzero normal")

endmodule

/* hw/rtl/quad_surface_vertex_normals_unit.sv */
// corner 0 of an accepted quad leaves first, corners 1..3 follow in order; every stage
//   holds while the output item is not taken
// the corner pipeline takes one corner a cycle unless the output stalls; a new quad is taken
// once its predecessor's last corner issues; rst_n clears all valid state and sets shift_reg to 6
// ----------------------------------------------------------------------------
// quad_surface_vertex_normals_unit
// newell quad normal and per-corner normals, normalized to q1.14
// ----------------------------------------------------------------------------
module quad_surface_vertex_normals_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [qsvn_pkg::SHIFT_W-1:0]        cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c0_x,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c0_y,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c0_z,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c1_x,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c1_y,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c1_z,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c2_x,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c2_y,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c2_z,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c3_x,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c3_y,
    input  logic signed [qsvn_pkg::COORD_W-1:0] c3_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          corner_index,
    output logic signed [qsvn_pkg::NORM_W-1:0]  corner_nx,
    output logic signed [qsvn_pkg::NORM_W-1:0]  corner_ny,
    output logic signed [qsvn_pkg::NORM_W-1:0]  corner_nz,
    output logic signed [qsvn_pkg::NORM_W-1:0]  quad_nx,
    output logic signed [qsvn_pkg::NORM_W-1:0]  quad_ny,
    output logic signed [qsvn_pkg::NORM_W-1:0]  quad_nz,
    output logic                                surface_valid,
    output logic                                last_corner
);
    import qsvn_pkg::*;

    logic [SHIFT_W-1:0] shift_reg;
    logic               busy_reg;
    logic [1:0]         cnt_reg;
    coord_t             pos_reg [4][3];

    job_t               cjob_reg;
    job_t               qjob_reg;
    edge_t              ca_reg [3];
    edge_t              cb_reg [3];
    edge_t              qa_reg [3];
    edge_t              qb_reg [3];

    vec_res_t           corner_res;
    vec_res_t           quad_res;

    logic               adv;
    logic               accept;
    logic               issue;

    assign adv      = !out_valid || out_ready;
    assign in_ready = !busy_reg || ((cnt_reg == 2'd3) && adv);
    assign accept   = in_valid && in_ready;
    assign issue    = busy_reg && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_wr_en)
        begin
            shift_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 2'd0;
        end
        else if (issue)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // corners rotate so the current one always sits in slot 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0][0] <= c0_x;
            pos_reg[0][1] <= c0_y;
            pos_reg[0][2] <= c0_z;
            pos_reg[1][0] <= c1_x;
            pos_reg[1][1] <= c1_y;
            pos_reg[1][2] <= c1_z;
            pos_reg[2][0] <= c2_x;
            pos_reg[2][1] <= c2_y;
            pos_reg[2][2] <= c2_z;
            pos_reg[3][0] <= c3_x;
            pos_reg[3][1] <= c3_y;
            pos_reg[3][2] <= c3_z;
        end
        else if (issue)
        begin
            pos_reg[0] <= pos_reg[1];
            pos_reg[1] <= pos_reg[2];
            pos_reg[2] <= pos_reg[3];
            pos_reg[3] <= pos_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cjob_reg <= '0;
            qjob_reg <= '0;
        end
        else if (adv)
        begin
            cjob_reg.vld <= busy_reg;
            cjob_reg.idx <= cnt_reg;
            qjob_reg.vld <= busy_reg && (cnt_reg == 2'd0);
            qjob_reg.idx <= 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ca_reg[k] <= EDGE_W'(pos_reg[1][k]) - EDGE_W'(pos_reg[0][k]);
                cb_reg[k] <= EDGE_W'(pos_reg[3][k]) - EDGE_W'(pos_reg[0][k]);
                // diagonals give the newell vector of a quad
                qa_reg[k] <= EDGE_W'(pos_reg[2][k]) - EDGE_W'(pos_reg[0][k]);
                qb_reg[k] <= EDGE_W'(pos_reg[3][k]) - EDGE_W'(pos_reg[1][k]);
            end
        end
    end

    qsvn_vec_pipe u_corner_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .job_in (cjob_reg),
        .a      (ca_reg),
        .b      (cb_reg),
        .res    (corner_res)
    );

    qsvn_vec_pipe u_quad_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .job_in (qjob_reg),
        .a      (qa_reg),
        .b      (qb_reg),
        .res    (quad_res)
    );

    qsvn_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .shift         (shift_reg),
        .corner        (corner_res),
        .quad          (quad_res),
        .out_valid     (out_valid),
        .corner_index  (corner_index),
        .corner_nx     (corner_nx),
        .corner_ny     (corner_ny),
        .corner_nz     (corner_nz),
        .quad_nx       (quad_nx),
        .quad_ny       (quad_ny),
        .quad_nz       (quad_nz),
        .surface_valid (surface_valid),
        .last_corner   (last_corner)
    );

endmodule
